[rtl/core/assert_macros.svh]
// Assertion helpers used by the record stack RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising clock edge outside reset.
`define RSU_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define RSU_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define RSU_ASSERT(lbl, clk, rstn, prop, msg)
`define RSU_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

[rtl/core/rsu_pkg.sv]
package rsu_pkg;

	typedef enum logic [1:0] {
		FN_PUSH   = 2'd0,
		FN_POP    = 2'd1,
		FN_LIST   = 2'd2,
		FN_UPDATE = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_PUSHED   = 3'd0,
		ST_POPPED   = 3'd1,
		ST_LISTED   = 3'd2,
		ST_UPDATED  = 3'd3,
		ST_EMPTY    = 3'd4,
		ST_NOTFOUND = 3'd5,
		ST_FULL     = 3'd6
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_RUN  = 1'b1
	} state_t;

	// HOLD keeps the record, DOWN takes the record from the cell above,
	// UP takes the record from the cell below (ring wraps to the top).
	typedef enum logic [1:0] {
		OP_HOLD = 2'd0,
		OP_DOWN = 2'd1,
		OP_UP   = 2'd2
	} cell_op_t;

	localparam int unsigned IdW   = 32;
	localparam int unsigned YearW = 16;
	localparam int unsigned NameW = 64;

endpackage

[rtl/core/record_stack_with_update.sv]
// Channel | Handshake             | Payload
// req     | req_valid / req_ready | func, team_id, name_word, founding_year
// rsp     | rsp_valid / rsp_ready | status, out_id, out_name, out_year, last
//
// Push and pop are captured while idle, then executed in the run state.
// List and update rotate the whole ring of STACK_DEPTH cells one step per
// cycle while no stalled rsp holds a step; on an empty stack they do not walk.
// arst_n clears the control state and the fill count; records are not reset.
// A stalled rsp only blocks a step that has a result to deliver; req is
// taken again as soon as the block is idle, even with a result still held.
module record_stack_with_update #(
	parameter int unsigned STACK_DEPTH = 16,
	parameter int unsigned NAME_BYTES  = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic [1:0]          func,
	input  logic signed [31:0]  team_id,
	input  logic [63:0]         name_word,
	input  logic [15:0]         founding_year,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output logic [2:0]          status,
	output logic signed [31:0]  out_id,
	output logic [63:0]         out_name,
	output logic [15:0]         out_year,
	output logic                last
);

	`include "assert_macros.svh"

	localparam int unsigned NW = 8 * NAME_BYTES;          // kept name bits
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1); // fill count
	localparam int unsigned SW = $clog2(STACK_DEPTH);     // walk step
	localparam int unsigned IW = rsu_pkg::IdW;
	localparam int unsigned YW = rsu_pkg::YearW;

	// Cell chain: index 0 is the top of stack.
	logic [IW-1:0] c_id   [STACK_DEPTH];
	logic [NW-1:0] c_name [STACK_DEPTH];
	logic [YW-1:0] c_year [STACK_DEPTH];

	rsu_pkg::cell_op_t cell_op;

	// Request registers
	rsu_pkg::func_t func_q;
	logic [IW-1:0]  key_q;
	logic [NW-1:0]  name_q;
	logic [YW-1:0]  year_q;

	rsu_pkg::state_t state_q, state_nxt;
	logic [CW-1:0]   count_q;
	logic [SW-1:0]   step_q;
	logic            found_q;

	// Response register
	logic                rsp_valid_q;
	rsu_pkg::status_t    status_q;
	logic [IW-1:0]       oid_q;
	logic [NW-1:0]       oname_q;
	logic [YW-1:0]       oyear_q;
	logic                last_q;

	// Step control
	logic             out_free;
	logic             go;
	logic             emit;
	rsu_pkg::status_t e_status;
	logic [IW-1:0]    e_id;
	logic [NW-1:0]    e_name;
	logic [YW-1:0]    e_year;
	logic             e_last;
	logic             cnt_inc, cnt_dec;
	logic             step_inc, walk_done, found_set;
	logic             in_range, at_end, hit, empty, full;
	logic [NW-1:0]    ring_name;
	logic [YW-1:0]    ring_year;

	assign out_free = !rsp_valid_q || rsp_ready;
	assign empty    = (count_q == '0);
	assign full     = (count_q == CW'(STACK_DEPTH));
	assign in_range = (CW'(step_q) < count_q);
	assign at_end   = (step_q == SW'(STACK_DEPTH - 1));
	assign hit      = (func_q == rsu_pkg::FN_UPDATE) && in_range && !found_q
		&& (c_id[0] == key_q);

	// Update rewrites the matching record as it passes from the top
	// around the ring to the bottom cell.
	assign ring_name = hit ? name_q : c_name[0];
	assign ring_year = hit ? year_q : c_year[0];

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_top
			if (STACK_DEPTH == 1) begin : g_one
				rsu_cell #(.NW(NW)) u_cell (
					.clk(clk), .op(cell_op),
					.up_id(key_q), .up_name(name_q), .up_year(year_q),
					.dn_id(c_id[0]), .dn_name(ring_name), .dn_year(ring_year),
					.id(c_id[i]), .name(c_name[i]), .year(c_year[i])
				);
			end else begin : g_many
				rsu_cell #(.NW(NW)) u_cell (
					.clk(clk), .op(cell_op),
					.up_id(key_q), .up_name(name_q), .up_year(year_q),
					.dn_id(c_id[i+1]), .dn_name(c_name[i+1]), .dn_year(c_year[i+1]),
					.id(c_id[i]), .name(c_name[i]), .year(c_year[i])
				);
			end
		end else if (i == STACK_DEPTH - 1) begin : g_bot
			rsu_cell #(.NW(NW)) u_cell (
				.clk(clk), .op(cell_op),
				.up_id(c_id[i-1]), .up_name(c_name[i-1]), .up_year(c_year[i-1]),
				.dn_id(c_id[0]), .dn_name(ring_name), .dn_year(ring_year),
				.id(c_id[i]), .name(c_name[i]), .year(c_year[i])
			);
		end else begin : g_mid
			rsu_cell #(.NW(NW)) u_cell (
				.clk(clk), .op(cell_op),
				.up_id(c_id[i-1]), .up_name(c_name[i-1]), .up_year(c_year[i-1]),
				.dn_id(c_id[i+1]), .dn_name(c_name[i+1]), .dn_year(c_year[i+1]),
				.id(c_id[i]), .name(c_name[i]), .year(c_year[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsu_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state, cell control and the result of the current step
	always_comb begin
		state_nxt = state_q;
		cell_op   = rsu_pkg::OP_HOLD;
		emit      = 1'b0;
		e_status  = rsu_pkg::ST_EMPTY;
		e_id      = '0;
		e_name    = '0;
		e_year    = '0;
		e_last    = 1'b1;
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		step_inc  = 1'b0;
		walk_done = 1'b0;
		found_set = 1'b0;
		go        = 1'b0;
		unique case (state_q)
			rsu_pkg::S_IDLE: begin
				if (req_valid) begin
					state_nxt = rsu_pkg::S_RUN;
				end
			end
			rsu_pkg::S_RUN: begin
				if (func_q == rsu_pkg::FN_PUSH) begin
					emit = 1'b1;
					go   = out_free;
					if (full) begin
						e_status = rsu_pkg::ST_FULL;
					end else begin
						e_status = rsu_pkg::ST_PUSHED;
						e_id     = key_q;
						e_name   = name_q;
						e_year   = year_q;
						cnt_inc  = go;
						cell_op  = go ? rsu_pkg::OP_DOWN : rsu_pkg::OP_HOLD;
					end
					if (go) state_nxt = rsu_pkg::S_IDLE;
				end else if (empty) begin
					emit = 1'b1;
					go   = out_free;
					if (go) state_nxt = rsu_pkg::S_IDLE;
				end else if (func_q == rsu_pkg::FN_POP) begin
					emit     = 1'b1;
					go       = out_free;
					e_status = rsu_pkg::ST_POPPED;
					e_id     = c_id[0];
					e_name   = c_name[0];
					e_year   = c_year[0];
					cnt_dec  = go;
					cell_op  = go ? rsu_pkg::OP_UP : rsu_pkg::OP_HOLD;
					if (go) state_nxt = rsu_pkg::S_IDLE;
				end else begin
					// Ring walk: one full rotation, top record seen each step
					if (func_q == rsu_pkg::FN_LIST) begin
						emit     = in_range;
						e_status = rsu_pkg::ST_LISTED;
						e_id     = c_id[0];
						e_name   = c_name[0];
						e_year   = c_year[0];
						e_last   = (CW'(step_q) == count_q - CW'(1));
					end else begin
						emit = hit || (at_end && !found_q);
						if (hit) begin
							e_status  = rsu_pkg::ST_UPDATED;
							e_id      = c_id[0];
							e_name    = name_q;
							e_year    = year_q;
						end else begin
							e_status  = rsu_pkg::ST_NOTFOUND;
						end
					end
					go        = !emit || out_free;
					found_set = go && hit;
					cell_op   = go ? rsu_pkg::OP_UP : rsu_pkg::OP_HOLD;
					step_inc  = go && !at_end;
					walk_done = go && at_end;
					if (walk_done) state_nxt = rsu_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = rsu_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			step_q      <= '0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (walk_done) begin
				step_q  <= '0;
				found_q <= 1'b0;
			end else begin
				if (step_inc) step_q <= step_q + SW'(1);
				if (found_set) found_q <= 1'b1;
			end
			if (emit && go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Request capture; name keeps only its low NAME_BYTES bytes
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			func_q <= rsu_pkg::func_t'(func);
			key_q  <= team_id;
			name_q <= name_word[NW-1:0];
			year_q <= founding_year;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && go) begin
			status_q <= e_status;
			oid_q    <= e_id;
			oname_q  <= e_name;
			oyear_q  <= e_year;
			last_q   <= e_last;
		end
	end

	assign req_ready = (state_q == rsu_pkg::S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;
	assign out_id    = oid_q;
	assign out_name  = {{(rsu_pkg::NameW - NW){1'b0}}, oname_q} ;
	assign out_year  = oyear_q;
	assign last      = last_q;

	`RSU_NEVER(a_count_bound, clk, arst_n, count_q > CW'(STACK_DEPTH), "fill count over depth")
	`RSU_ASSERT(a_accept_runs, clk, arst_n, (req_valid && req_ready) |=> (state_q == rsu_pkg::S_RUN), "accepted request not executed")
	`RSU_ASSERT(a_idle_step, clk, arst_n, (state_q == rsu_pkg::S_IDLE) |-> (step_q == '0 && !found_q), "walk state left over in idle")
	`RSU_ASSERT(a_single_last, clk, arst_n, (rsp_valid && status != rsu_pkg::ST_LISTED) |-> last, "single result without last")
	`RSU_ASSERT(a_push_count, clk, arst_n, (cnt_inc && !cnt_dec) |=> (count_q == $past(count_q) + CW'(1)), "push did not grow stack")

endmodule

[rtl/core/rsu_cell.sv]
// One stack slot: a record register that loads from either neighbor (the top slot takes new pushes).
module rsu_cell #(
	parameter int unsigned NW = 64
) (
	input  logic                        clk,
	input  rsu_pkg::cell_op_t           op,
	input  logic [rsu_pkg::IdW-1:0]     up_id,
	input  logic [NW-1:0]               up_name,
	input  logic [rsu_pkg::YearW-1:0]   up_year,
	input  logic [rsu_pkg::IdW-1:0]     dn_id,
	input  logic [NW-1:0]               dn_name,
	input  logic [rsu_pkg::YearW-1:0]   dn_year,
	output logic [rsu_pkg::IdW-1:0]     id,
	output logic [NW-1:0]               name,
	output logic [rsu_pkg::YearW-1:0]   year
);

	logic [rsu_pkg::IdW-1:0]   id_q;
	logic [NW-1:0]             name_q;
	logic [rsu_pkg::YearW-1:0] year_q;

	always_ff @(posedge clk) begin
		case (op)
			rsu_pkg::OP_DOWN: begin
				id_q   <= up_id;
				name_q <= up_name;
				year_q <= up_year;
			end
			rsu_pkg::OP_UP: begin
				id_q   <= dn_id;
				name_q <= dn_name;
				year_q <= dn_year;
			end
			default: begin
				id_q   <= id_q;
				name_q <= name_q;
				year_q <= year_q;
			end
		endcase
	end

	assign id   = id_q;
	assign name = name_q;
	assign year = year_q;

endmodule

[bench/tb_top.sv]
import rsu_pkg::*;

localparam int unsigned TB_DEPTH      = 16;
localparam int unsigned TB_NAME_BYTES = 8;
localparam logic [63:0] NAME_MASK     = (TB_NAME_BYTES >= 8) ? 64'hFFFF_FFFF_FFFF_FFFF :
	((64'd1 << (8 * TB_NAME_BYTES)) - 64'd1);

typedef struct packed {
	logic signed [31:0] id;
	logic [63:0]        name;
	logic [15:0]        year;
} team_rec_t;

typedef struct packed {
	status_t   status;
	team_rec_t rec;
	logic      lst;
} team_rsp_t;

// Mirror of the record stack plus the queue of results it still owes.
class team_stack_model;
	team_rec_t   slots[TB_DEPTH];
	int unsigned fill;
	team_rsp_t   pending[$];
	int unsigned by_func[4];
	int unsigned by_status[7];
	int unsigned top_fill;

	function new();
		fill = 0;
		top_fill = 0;
		foreach (by_func[i]) by_func[i] = 0;
		foreach (by_status[i]) by_status[i] = 0;
	endfunction

	function void add_expect(status_t st, team_rec_t rec, logic lst);
		team_rsp_t r;
		r.status = st;
		r.rec    = rec;
		r.lst    = lst;
		pending.push_back(r);
	endfunction

	function void note_request(func_t fn, logic signed [31:0] id, logic [63:0] name,
			logic [15:0] year);
		team_rec_t rec;
		int        i;
		bit        hit;
		rec.id   = id;
		rec.name = name & NAME_MASK;
		rec.year = year;
		hit      = 0;
		by_func[fn]++;
		case (fn)
			FN_PUSH: begin
				if (fill >= TB_DEPTH) begin
					add_expect(ST_FULL, '0, 1'b1);
				end else begin
					slots[fill] = rec;
					fill++;
					add_expect(ST_PUSHED, rec, 1'b1);
				end
			end
			FN_POP: begin
				if (fill == 0) begin
					add_expect(ST_EMPTY, '0, 1'b1);
				end else begin
					fill--;
					add_expect(ST_POPPED, slots[fill], 1'b1);
				end
			end
			FN_LIST: begin
				if (fill == 0)
					add_expect(ST_EMPTY, '0, 1'b1);
				else
					for (i = int'(fill) - 1; i >= 0; i--)
						add_expect(ST_LISTED, slots[i], i == 0);
			end
			default: begin
				if (fill == 0) begin
					add_expect(ST_EMPTY, '0, 1'b1);
				end else begin
					// topmost match wins
					for (i = int'(fill) - 1; i >= 0 && !hit; i--) begin
						if (slots[i].id == id) begin
							slots[i].name = rec.name;
							slots[i].year = rec.year;
							add_expect(ST_UPDATED, slots[i], 1'b1);
							hit = 1;
						end
					end
					if (!hit)
						add_expect(ST_NOTFOUND, '0, 1'b1);
				end
			end
		endcase
		if (fill > top_fill)
			top_fill = fill;
	endfunction

	// Empty string means the result matched.
	function string check_result(logic [2:0] st, logic signed [31:0] id, logic [63:0] name,
			logic [15:0] year, logic lst);
		team_rsp_t want;
		string     why;
		if (pending.size() == 0)
			return $sformatf("result with nothing expected: status %0d id %0d", st, id);
		want = pending.pop_front();
		by_status[want.status]++;
		why = "";
		if (st !== want.status)
			why = {why, $sformatf(" status %0d/%0d", st, want.status)};
		if (id !== want.rec.id)
			why = {why, $sformatf(" id %0d/%0d", id, want.rec.id)};
		if (name !== want.rec.name)
			why = {why, $sformatf(" name %h/%h", name, want.rec.name)};
		if (year !== want.rec.year)
			why = {why, $sformatf(" year %0d/%0d", year, want.rec.year)};
		if (lst !== want.lst)
			why = {why, $sformatf(" last %0b/%0b", lst, want.lst)};
		if (why != "")
			why = {"result field mismatch (got/expected):", why};
		return why;
	endfunction

	function int unsigned pending_count();
		return pending.size();
	endfunction

	function int unsigned depth_now();
		return fill;
	endfunction

	function logic signed [31:0] id_at(int unsigned idx);
		return slots[idx].id;
	endfunction
endclass

module tb_top;

	// Cycles with no handshake on either channel before we give up. The long
	// receiver hold-off is the worst legal quiet stretch.
	localparam int unsigned WATCHDOG_LIMIT = 1500;
	localparam int unsigned HOLD_CYCLES    = 160;
	localparam int unsigned RANDOM_ITEMS   = 150;
	localparam int unsigned MAX_PRINTED    = 60;

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_ready;
	logic [1:0]         func;
	logic signed [31:0] team_id;
	logic [63:0]        name_word;
	logic [15:0]        founding_year;
	logic               rsp_valid;
	logic               rsp_ready;
	logic [2:0]         status;
	logic signed [31:0] out_id;
	logic [63:0]        out_name;
	logic [15:0]        out_year;
	logic               last;

	team_stack_model model = new();

	int unsigned fail_count;
	int unsigned idle_cycles;
	int unsigned req_taken;
	int unsigned rsp_taken;
	int unsigned burst_left;
	bit          pressure_go;
	string       mismatch_text;

	record_stack_with_update #(
		.STACK_DEPTH(TB_DEPTH),
		.NAME_BYTES (TB_NAME_BYTES)
	) uut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report_mismatch(string msg);
		fail_count++;
		if (fail_count <= MAX_PRINTED)
			$display("MISMATCH @%0t: %s", $realtime, msg);
	endtask

	// Everything is sampled at the rising edge; inputs move only at the
	// falling edge, so the values read here are stable.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) begin
				model.note_request(func_t'(func), team_id, name_word, founding_year);
				req_taken++;
			end
			if (rsp_valid && rsp_ready) begin
				mismatch_text = model.check_result(status, out_id, out_name, out_year, last);
				if (mismatch_text != "")
					report_mismatch(mismatch_text);
				rsp_taken++;
			end
		end
	end

	// Watchdog: counts cycles with no handshake at all.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TIMEOUT: no handshake for %0d cycles, %0d results still owed",
					idle_cycles, model.pending_count());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Result side. Random stall pattern, picked anew for each run of random length:
	// always ready, coin flip, or a regular one-in-three stall. Once the
	// stimulus raises pressure_go, ready is held low for a long stretch so
	// the held result backs up and the block stops taking requests.
	initial begin : rsp_side
		int unsigned mode;
		int unsigned run_left;
		int unsigned phase;
		int unsigned hold_cnt;
		bit          held;
		mode     = 0;
		run_left = 0;
		phase    = 0;
		held     = 0;
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (pressure_go && !held) begin
				rsp_ready <= 1'b0;
				for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
					@(negedge clk);
				held = 1;
			end
			if (run_left == 0) begin
				mode     = $urandom_range(0, 2);
				run_left = $urandom_range(8, 40);
			end
			run_left--;
			phase++;
			case (mode)
				0:       rsp_ready <= 1'b1;
				1:       rsp_ready <= 1'($urandom_range(0, 1));
				default: rsp_ready <= (phase % 3) != 0;
			endcase
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance
	// with valid still high, so the next request can follow back to back.
	task automatic send_request(func_t fn, logic signed [31:0] id, logic [63:0] name,
			logic [15:0] year);
		req_valid     <= 1'b1;
		func          <= fn;
		team_id       <= id;
		name_word     <= name;
		founding_year <= year;
		do
			@(posedge clk);
		while (!req_ready);
		@(negedge clk);
	endtask

	// Sender works in bursts; between bursts valid drops for a random gap.
	// Now and then a long burst runs with no gaps at all.
	task automatic pace_sender();
		int unsigned gap;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) :
				$urandom_range(1, 10);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	task automatic issue(func_t fn, logic signed [31:0] id, logic [63:0] name,
			logic [15:0] year);
		send_request(fn, id, name, year);
		pace_sender();
	endtask

	// Ids: often one already on the stack (update hits, duplicates), some from
	// a tiny pool around zero, the rest fully random.
	function automatic logic signed [31:0] pick_id(int unsigned reuse_pct);
		if (model.depth_now() > 0 && $urandom_range(0, 99) < reuse_pct)
			return model.id_at($urandom_range(0, model.depth_now() - 1));
		if ($urandom_range(0, 2) == 0)
			return 32'($urandom_range(0, 7)) - 32'd3;
		return $urandom;
	endfunction

	function automatic logic [63:0] pick_name();
		case ($urandom_range(0, 9))
			0:       return 64'hFFFF_FFFF_FFFF_FFFF;
			1:       return 64'h0;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// mode 0 leans to push (fill), 1 leans to pop (drain), 2 is mixed
	task automatic random_item(int unsigned mode);
		int unsigned roll;
		func_t       fn;
		roll = $urandom_range(0, 99);
		case (mode)
			0:       fn = (roll < 70) ? FN_PUSH : (roll < 78) ? FN_POP :
				(roll < 86) ? FN_LIST : FN_UPDATE;
			1:       fn = (roll < 20) ? FN_PUSH : (roll < 70) ? FN_POP :
				(roll < 80) ? FN_LIST : FN_UPDATE;
			default: fn = (roll < 35) ? FN_PUSH : (roll < 60) ? FN_POP :
				(roll < 72) ? FN_LIST : FN_UPDATE;
		endcase
		issue(fn, pick_id((fn == FN_UPDATE) ? 60 : 20), pick_name(),
			16'($urandom_range(0, 65535)));
	endtask

	initial begin : stim
		int unsigned n;
		int unsigned k;
		int unsigned mode;
		int unsigned round_len;
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		func          = FN_PUSH;
		team_id       = '0;
		name_word     = '0;
		founding_year = '0;
		fail_count    = 0;
		idle_cycles   = 0;
		req_taken     = 0;
		rsp_taken     = 0;
		burst_left    = 0;
		pressure_go   = 0;
		n             = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: every operation on an empty stack, extreme field values,
		// duplicate ids so update must pick the topmost, a miss, a search that
		// walks down to the bottom record, then drain past empty.
		issue(FN_POP, 32'sd0, 64'h0, 16'd0);
		issue(FN_LIST, 32'sd0, 64'h0, 16'd0);
		issue(FN_UPDATE, 32'sd0, 64'h0, 16'd0);
		issue(FN_PUSH, 32'sh8000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
		issue(FN_PUSH, 32'sh7FFF_FFFF, 64'h0, 16'h0000);
		issue(FN_PUSH, 32'sd5, 64'h0041_4853_4C41_4E41, 16'd1900);
		issue(FN_PUSH, 32'sd5, 64'h0000_0053_4F54_4F42, 16'd2001);
		issue(FN_UPDATE, 32'sd5, 64'h5A5A_A5A5_0F0F_F0F0, 16'd1234);
		issue(FN_UPDATE, 32'sd12345, 64'h1, 16'd1);
		issue(FN_UPDATE, 32'sh8000_0000, 64'h0123_4567_89AB_CDEF, 16'h8000);
		issue(FN_LIST, 32'sd0, 64'h0, 16'd0);
		issue(FN_POP, 32'sd0, 64'h0, 16'd0);
		issue(FN_POP, 32'sd0, 64'h0, 16'd0);
		issue(FN_UPDATE, 32'sd5, 64'h2, 16'd2);
		issue(FN_LIST, 32'sd0, 64'h0, 16'd0);
		issue(FN_POP, 32'sd0, 64'h0, 16'd0);
		issue(FN_POP, 32'sd0, 64'h0, 16'd0);
		issue(FN_POP, 32'sd0, 64'h0, 16'd0);

		// Fill past the top while the result side is held off: the block must
		// back up, then refuse the extra pushes once it is full. A full-depth
		// list and a search for the bottom record follow.
		pressure_go = 1;
		for (k = 0; k < TB_DEPTH + 3; k++) begin
			issue(FN_PUSH, pick_id(10), pick_name(), 16'($urandom_range(0, 65535)));
			n++;
		end
		issue(FN_LIST, $urandom, pick_name(), 16'($urandom_range(0, 65535)));
		issue(FN_UPDATE, model.id_at(0), pick_name(), 16'($urandom_range(0, 65535)));
		n += 2;

		// Random rounds, each biased toward filling, draining or a mix.
		while (n < RANDOM_ITEMS) begin
			mode      = $urandom_range(0, 2);
			round_len = $urandom_range(8, 30);
			for (k = 0; k < round_len && n < RANDOM_ITEMS; k++) begin
				random_item(mode);
				n++;
			end
		end
		req_valid <= 1'b0;

		while (model.pending_count() != 0)
			@(posedge clk);
		// a list can still be walking the ring; leave room for strays
		repeat (2 * TB_DEPTH + 8) @(posedge clk);
		if (model.pending_count() != 0)
			report_mismatch("results still missing at end of run");

		$display("Run covered %0d requests (push %0d, pop %0d, list %0d, update %0d), %0d results, peak depth %0d",
			req_taken, model.by_func[FN_PUSH], model.by_func[FN_POP],
			model.by_func[FN_LIST], model.by_func[FN_UPDATE], rsp_taken, model.top_fill);
		$display("Outcomes: full %0d, empty %0d, update hit %0d, update miss %0d, listed %0d, mismatches %0d",
			model.by_status[ST_FULL], model.by_status[ST_EMPTY], model.by_status[ST_UPDATED],
			model.by_status[ST_NOTFOUND], model.by_status[ST_LISTED], fail_count);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
